// ===== rtl/core/rta_pkg.sv =====
`default_nettype none
package rta_pkg;

	localparam int unsigned ValueBits = 64;

	typedef enum logic [1:0] {
		FUNC_DEC    = 2'd0,
		FUNC_OCT    = 2'd1,
		FUNC_HEX_UP = 2'd2,
		FUNC_HEX_LO = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_SKIP,
		ST_EMIT,
		ST_EMPTY
	} state_t;

	typedef struct packed {
		logic load;
		logic dabble;
		logic shift;
		logic emit_empty;
	} cmd_t;

	typedef struct packed {
		logic empty_in;
		logic dec_in;
		logic bit_done;
		logic top_zero;
		logic cnt_one;
	} status_t;

	function automatic logic [6:0] ascii_digit(input logic [3:0] d, input logic lower);
		logic [6:0] c;
		begin
			if (d < 4'd10) begin
				c = 7'h30 + 7'(d);
			end else if (lower) begin
				c = 7'h61 + 7'(d) - 7'd10;
			end else begin
				c = 7'h41 + 7'(d) - 7'd10;
			end
			return c;
		end
	endfunction

endpackage
`default_nettype wire

// ===== rtl/core/rta_in_if.sv =====
`default_nettype none
interface rta_in_if;
	import rta_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [ValueBits-1:0] value;
	logic [1:0]           func;
	logic                 precision_zero;

	modport source (output valid, output value, output func, output precision_zero,
		input ready);
	modport sink (input valid, input value, input func, input precision_zero,
		output ready);
endinterface
`default_nettype wire

// ===== rtl/core/rta_out_if.sv =====
`default_nettype none
interface rta_out_if;
	logic       valid;
	logic       ready;
	logic [6:0] digit_char;
	logic       last;
	logic       empty_res;

	modport source (output valid, output digit_char, output last, output empty_res,
		input ready);
	modport sink (input valid, input digit_char, input last, input empty_res,
		output ready);
endinterface
`default_nettype wire

// ===== rtl/core/unsigned_radix_to_ascii_unit.sv =====
`default_nettype none
// Sequence: after accept, octal and hex skip leading zero digits, then emit the digits from the top down.
// Decimal first runs the one-bit-per-cycle shift-and-add-3 loop over all VALUE_WIDTH bits.
// A new item is accepted only in idle, after the last digit of the previous one; each digit holds until dout.ready.
// Zero with zero precision: one empty result in the cycle after accept.
// Reset: asynchronous arst_n returns the controller to idle; no other state is cleared.
module unsigned_radix_to_ascii_unit #(
	parameter int unsigned VALUE_WIDTH = 64
) (
	input  wire logic clk,
	input  wire logic arst_n,
	rta_in_if.sink    din,
	rta_out_if.source dout
);
	import rta_pkg::*;

	cmd_t    cmd;
	status_t sts;
	logic    in_ready;
	logic    out_valid;

	rta_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (din.valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (dout.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	rta_datapath #(
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_datapath (
		.clk               (clk),
		.in_value          (din.value),
		.in_func           (din.func),
		.in_precision_zero (din.precision_zero),
		.cmd               (cmd),
		.sts               (sts),
		.digit_char        (dout.digit_char),
		.last              (dout.last),
		.empty_res         (dout.empty_res)
	);

	assign din.ready  = in_ready;
	assign dout.valid = out_valid;
endmodule
`default_nettype wire

// ===== rtl/core/rta_ctrl.sv =====
`default_nettype none
module rta_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  wire logic            out_ready,
	input  wire rta_pkg::status_t sts,
	output rta_pkg::cmd_t        cmd
);
	import rta_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					if (sts.empty_in) begin
						state_d = ST_EMPTY;
					end else if (sts.dec_in) begin
						state_d = ST_CONV;
					end else begin
						state_d = ST_SKIP;
					end
				end
			end
			ST_CONV: begin
				cmd.dabble = 1'b1;
				if (sts.bit_done) begin
					state_d = ST_SKIP;
				end
			end
			ST_SKIP: begin
				if (sts.top_zero && !sts.cnt_one) begin
					cmd.shift = 1'b1;
				end else begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					cmd.shift = 1'b1;
					if (sts.cnt_one) begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_EMPTY: begin
				out_valid      = 1'b1;
				cmd.emit_empty = 1'b1;
				if (out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end
endmodule
`default_nettype wire

// ===== rtl/core/rta_datapath.sv =====
`default_nettype none
module rta_datapath #(
	parameter int unsigned VALUE_WIDTH = 64
) (
	input  wire logic                          clk,
	input  wire logic [rta_pkg::ValueBits-1:0] in_value,
	input  wire logic [1:0]                    in_func,
	input  wire logic                          in_precision_zero,
	input  wire rta_pkg::cmd_t                 cmd,
	output rta_pkg::status_t                   sts,
	output logic [6:0]                         digit_char,
	output logic                               last,
	output logic                               empty_res
);
	import rta_pkg::*;

	localparam int unsigned NDIG = (VALUE_WIDTH + 2) / 3;
	localparam int unsigned PADW = NDIG * 4;
	localparam int unsigned BW   = $clog2(VALUE_WIDTH);
	localparam int unsigned CW   = $clog2(NDIG + 1);

	logic [PADW-1:0]        digits_q;
	logic [VALUE_WIDTH-1:0] val_q;
	logic [BW-1:0]          bit_q;
	logic [CW-1:0]          cnt_q;
	logic                   lower_q;

	logic [VALUE_WIDTH-1:0] val_in;
	logic [PADW-1:0]        pad_in;
	logic [PADW-1:0]        oct_in;
	logic [PADW-1:0]        adj;
	logic [3:0]             top;

	assign val_in = in_value[VALUE_WIDTH-1:0];
	assign pad_in = PADW'(val_in);
	assign top    = digits_q[PADW-1 -: 4];

	always_comb begin
		for (int i = 0; i < NDIG; i++) begin
			oct_in[4*i +: 4] = {1'b0, pad_in[3*i +: 3]};
			if (digits_q[4*i +: 4] >= 4'd5) begin
				adj[4*i +: 4] = digits_q[4*i +: 4] + 4'd3;
			end else begin
				adj[4*i +: 4] = digits_q[4*i +: 4];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			val_q   <= val_in;
			bit_q   <= BW'(VALUE_WIDTH - 1);
			cnt_q   <= CW'(NDIG);
			lower_q <= (func_t'(in_func) == FUNC_HEX_LO);
			unique case (func_t'(in_func))
				FUNC_DEC:                 digits_q <= '0;
				FUNC_OCT:                 digits_q <= oct_in;
				FUNC_HEX_UP, FUNC_HEX_LO: digits_q <= pad_in;
				default:                  digits_q <= pad_in;
			endcase
		end else if (cmd.dabble) begin
			digits_q <= {adj[PADW-2:0], val_q[VALUE_WIDTH-1]};
			val_q    <= {val_q[VALUE_WIDTH-2:0], 1'b0};
			bit_q    <= bit_q - BW'(1);
		end else if (cmd.shift) begin
			digits_q <= {digits_q[PADW-5:0], 4'd0};
			cnt_q    <= cnt_q - CW'(1);
		end
	end

	always_comb begin
		sts.empty_in = (val_in == '0) && in_precision_zero;
		sts.dec_in   = (func_t'(in_func) == FUNC_DEC);
		sts.bit_done = (bit_q == '0);
		sts.top_zero = (top == 4'd0);
		sts.cnt_one  = (cnt_q == CW'(1));
	end

	assign digit_char = cmd.emit_empty ? 7'd0 : ascii_digit(top, lower_q);
	assign last       = cmd.emit_empty | sts.cnt_one;
	assign empty_res  = cmd.emit_empty;
endmodule
`default_nettype wire
